>>> hdl/nwsd_pkg.sv
// Package for the nearest wall signed distance block.
// Holds op codes and shared widths; no dependencies.
package nwsd_pkg;
    localparam int COORD_W = 24;
    localparam int NORM_W  = 16;
    localparam int DIST_W  = 26;
    localparam int IDX_W   = 10;
    localparam int DIFF_W  = 25;
    localparam int SQ_W    = 50;
    localparam int ROOT_W  = 25;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // only computed cells are stored as wall points
    localparam logic [1:0] FLAG_COMPUTED = 2'd1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 26'sd33554431;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
endpackage

>>> hdl/nearest_wall_signed_distance.sv
// Top level of the nearest wall signed distance block.
// Depends on nwsd_pkg and nwsd_sqrt.
//
// Command interface: a transaction is taken when start is high and busy is low.
// Clear and add complete at the accepting edge and busy stays low, so they can
// follow back to back. A query scans every stored wall point through the
// position memory, one entry per cycle, then drains the pipeline tail,
// rereads the nearest entry, forms the dot product with its normal and runs
// a bit-serial square root; the result then shows and busy drops the cycle
// after. The result appears for one cycle with valid high; the receiver cannot
// stall it. An empty table gives no_wall with the largest positive distance in
// the cycle after acceptance.
module nearest_wall_signed_distance #(
    parameter int MAX_WALL_POINTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic signed [nwsd_pkg::COORD_W-1:0] x,
    input  logic signed [nwsd_pkg::COORD_W-1:0] y,
    input  logic signed [nwsd_pkg::COORD_W-1:0] z,
    input  logic signed [nwsd_pkg::NORM_W-1:0]  nx,
    input  logic signed [nwsd_pkg::NORM_W-1:0]  ny,
    input  logic signed [nwsd_pkg::NORM_W-1:0]  nz,
    input  logic [1:0]                    cell_flag,
    output logic                          valid,
    output logic signed [nwsd_pkg::DIST_W-1:0] signed_distance,
    output logic [nwsd_pkg::IDX_W-1:0]    nearest_index,
    output logic                          no_wall
);
    import nwsd_pkg::*;

    localparam int AW = (MAX_WALL_POINTS > 1) ? $clog2(MAX_WALL_POINTS) : 1;
    localparam int CW = $clog2(MAX_WALL_POINTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_DOT2 = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    // wall memories, one read port with registered data
    logic [3*COORD_W-1:0] pos_mem [MAX_WALL_POINTS];
    logic [3*NORM_W-1:0]  nrm_mem [MAX_WALL_POINTS];
    logic [3*COORD_W-1:0] pos_rd_reg;
    logic [3*NORM_W-1:0]  nrm_rd_reg;
    logic [AW-1:0]        rd_addr;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          rdv_reg;
    logic [AW-1:0] rdi_reg;
    coord_t        qx_reg, qy_reg, qz_reg;

    logic accept, wr_en;
    assign accept = start && !busy;
    assign wr_en  = accept && op == OP_ADD && cell_flag == FLAG_COMPUTED
                    && count_reg < CW'(MAX_WALL_POINTS);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[count_reg[AW-1:0]] <= {x, y, z};
            nrm_mem[count_reg[AW-1:0]] <= {nx, ny, nz};
        end
        pos_rd_reg <= pos_mem[rd_addr];
        nrm_rd_reg <= nrm_mem[rd_addr];
    end

    // stage 1: differences from registered read data
    logic signed [DIFF_W-1:0] dx, dy, dz;
    assign dx = DIFF_W'(signed'(pos_rd_reg[3*COORD_W-1 -: COORD_W])) - DIFF_W'(qx_reg);
    assign dy = DIFF_W'(signed'(pos_rd_reg[2*COORD_W-1 -: COORD_W])) - DIFF_W'(qy_reg);
    assign dz = DIFF_W'(signed'(pos_rd_reg[COORD_W-1 -: COORD_W])) - DIFF_W'(qz_reg);

    // full-width squares, 25x25 signed
    logic signed [2*DIFF_W-1:0] px, py, pz;
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    // stage 2: registered squares
    logic [SQ_W-1:0] sx_reg, sy_reg, sz_reg;
    logic            sqv_reg;
    logic [AW-1:0]   sqi_reg;
    // stage 3: sum and compare
    logic [SQ_W-1:0] sum;
    logic [SQ_W-1:0] best_d_reg;
    logic [AW-1:0]   best_i_reg;
    logic            have_reg;
    assign sum = SQ_W'(sx_reg + sy_reg + sz_reg);

    // dot-product datapath over the best entry, one product per cycle
    logic signed [DIFF_W-1:0] r_reg [3];
    logic signed [NORM_W-1:0] n_reg [3];
    logic [1:0]                   dk_reg;
    logic signed [DIFF_W+NORM_W+1:0] dot_reg;
    logic signed [DIFF_W+NORM_W-1:0] prod_prev;

    logic            sq_start;
    logic            sq_done;
    logic [ROOT_W-1:0] sq_root;

    nwsd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .radicand(best_d_reg), .done(sq_done), .root(sq_root)
    );

    logic valid_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic [IDX_W-1:0] idx_reg;
    logic nowall_reg;

    always_comb
    begin
        rd_addr = scan_reg[AW-1:0];
        if (state_reg == S_DOT)
            rd_addr = best_i_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        sq_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_CLEAR)
                        count_next = '0;
                    else if (wr_en)
                        count_next = count_reg + CW'(1);
                    else if (op == OP_QUERY && count_reg != '0)
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg < count_reg)
                    scan_next = scan_reg + CW'(1);
                else if (!rdv_reg && !sqv_reg)
                    state_next = S_DOT;
            end
            S_DOT:  state_next = S_DOT2;
            S_DOT2:
            begin
                if (dk_reg == 2'd3)
                begin
                    sq_start   = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: state_next = S_WAIT;
            S_WAIT:
            begin
                if (sq_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            rdv_reg   <= 1'b0;
            sqv_reg   <= 1'b0;
            have_reg  <= 1'b0;
            valid_reg <= 1'b0;
            dk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            rdv_reg   <= state_reg == S_SCAN && scan_reg < count_reg;
            sqv_reg   <= rdv_reg;
            if (accept && op == OP_QUERY)
                have_reg <= 1'b0;
            else if (sqv_reg)
                have_reg <= 1'b1;
            // dot counter: 0 load, 1..3 accumulate
            if (state_reg == S_DOT2)
                dk_reg <= dk_reg + 2'd1;
            else
                dk_reg <= '0;
            valid_reg <= (accept && op == OP_QUERY && count_reg == '0)
                         || (state_reg == S_WAIT && sq_done);
        end
    end

    // product for element dk-1, selected with the counter before increment
    always_comb
    begin
        prod_prev = '0;
        case (dk_reg)
            2'd1: prod_prev = r_reg[0] * n_reg[0];
            2'd2: prod_prev = r_reg[1] * n_reg[1];
            2'd3: prod_prev = r_reg[2] * n_reg[2];
            default: prod_prev = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= x;
            qy_reg <= y;
            qz_reg <= z;
        end
        rdi_reg <= scan_reg[AW-1:0];
        sqi_reg <= rdi_reg;
        sx_reg  <= unsigned'(px);
        sy_reg  <= unsigned'(py);
        sz_reg  <= unsigned'(pz);
        if (sqv_reg && (!have_reg || sum < best_d_reg))
        begin
            best_d_reg <= sum;
            best_i_reg <= sqi_reg;
        end
        if (state_reg == S_DOT2 && dk_reg == 2'd0)
        begin
            r_reg[0] <= dx;
            r_reg[1] <= dy;
            r_reg[2] <= dz;
            n_reg[0] <= signed'(nrm_rd_reg[3*NORM_W-1 -: NORM_W]);
            n_reg[1] <= signed'(nrm_rd_reg[2*NORM_W-1 -: NORM_W]);
            n_reg[2] <= signed'(nrm_rd_reg[NORM_W-1 -: NORM_W]);
            dot_reg  <= '0;
        end
        else if (state_reg == S_DOT2 || state_reg == S_ROOT)
        begin
            if (dk_reg != 2'd0 && dk_reg <= 2'd3 && state_reg == S_DOT2)
                dot_reg <= dot_reg + (DIFF_W+NORM_W+2)'(prod_prev);
        end
        if (accept && op == OP_QUERY && count_reg == '0)
        begin
            dist_reg   <= DIST_MAX;
            idx_reg    <= '0;
            nowall_reg <= 1'b1;
        end
        else if (state_reg == S_WAIT && sq_done)
        begin
            dist_reg   <= dot_reg < 0 ? DIST_W'(sq_root) : -DIST_W'(sq_root);
            idx_reg    <= IDX_W'(best_i_reg);
            nowall_reg <= 1'b0;
        end
    end

    assign busy            = state_reg != S_IDLE || valid_reg;
    assign valid           = valid_reg;
    assign signed_distance = dist_reg;
    assign nearest_index   = idx_reg;
    assign no_wall         = nowall_reg;
endmodule

>>> hdl/nwsd_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nwsd_pkg.
module nwsd_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nwsd_pkg::SQ_W-1:0]  radicand,
    output logic                       done,
    output logic [nwsd_pkg::ROOT_W-1:0] root
);
    import nwsd_pkg::*;

    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] res_reg, res_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [SQ_W+1:0]   trial;
    logic [SQ_W+1:0]   rem_sh;
    logic [SQ_W-1:0]   rad_reg;

    // restoring method: bring down two bits, test (4*res+1)
    always_comb
    begin
        rem_sh    = {rem_reg, 2'b00};
        trial     = {{(SQ_W+2-ROOT_W-2){1'b0}}, res_reg, 2'b01};
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            res_next = '0;
            cnt_next = 5'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_sh = {rem_reg[SQ_W-1:0], rad_reg[SQ_W-1 - 2*cnt_reg -: 2]};
            if (rem_sh >= trial)
            begin
                rem_next = SQ_W'(rem_sh - trial);
                res_next = {res_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = SQ_W'(rem_sh);
                res_next = {res_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(ROOT_W-1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            rad_reg <= radicand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule

>>> hdl/nwsd_checker.sv
// Port-level checker for the nearest wall signed distance block.
// Depends on nwsd_pkg; bound to the top level below.
module nwsd_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic valid,
    input logic no_wall,
    input logic [nwsd_pkg::IDX_W-1:0] nearest_index,
    input logic signed [nwsd_pkg::DIST_W-1:0] signed_distance
);
    import nwsd_pkg::*;

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid) else $error("result held more than one cycle");
    a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result shown while idle");
    a_nowall_idx: assert property (@(posedge clk) disable iff (!rst_n)
        valid && no_wall |-> nearest_index == '0 && signed_distance == DIST_MAX)
        else $error("empty table result wrong");
    a_after: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !busy) else $error("busy after result");
endmodule

bind nearest_wall_signed_distance nwsd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .valid(valid),
    .no_wall(no_wall), .nearest_index(nearest_index),
    .signed_distance(signed_distance)
);
